// ===== sv/vdm_pkg.sv =====
// ---------------------------------------------------------------------------
// vdm_pkg: shared types and constants for the vector distance block
// Metric codes, register indexes, result width and the multiplier response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vdm_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int P_MAX_DEF       = 8;

  localparam int DIST_W = 63;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // low slice of the multiplicand handled in the first multiplier pass
  localparam int LO_W = 32;
  localparam int HI_W = DIST_W - LO_W;

  // configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_P_EXP  = 1'b1;

  localparam logic [1:0] METRIC_SQ_EUCLID = 2'd0;
  localparam logic [1:0] METRIC_SUPREMUM  = 2'd1;
  localparam logic [1:0] METRIC_TRIVIAL   = 2'd2;
  localparam logic [1:0] METRIC_P_POWER   = 2'd3;

  localparam logic [3:0] P_EXP_RESET = 4'd2;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [DIST_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== sv/vdm_sat_mul.sv =====
// ---------------------------------------------------------------------------
// vdm_sat_mul: shared saturating multiplier
// Multiplies a 63-bit value by an unsigned coordinate difference in two
// passes (low 32 bits, then high bits) and clamps at the 63-bit maximum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vdm_sat_mul #(
  parameter int COORD_WIDTH = vdm_pkg::COORD_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire  [vdm_pkg::DIST_W-1:0]    x,
  input  wire  [COORD_WIDTH-1:0]        y,
  output vdm_pkg::mul_rsp_t             rsp
);

  localparam int LO_PW = vdm_pkg::LO_W + COORD_WIDTH;
  localparam int HI_PW = vdm_pkg::HI_W + COORD_WIDTH;
  localparam int T_W   = HI_PW + 1;

  logic                       ph_r;
  logic                       done_r;
  logic                       ovf_r;
  logic [LO_PW-1:0]           plo_r;
  logic [vdm_pkg::DIST_W-1:0] prod_r;

  logic [LO_PW-1:0] lo_prod;
  logic [HI_PW-1:0] hi_prod;
  logic [T_W-1:0]   t_sum;
  logic             t_ovf;

  // x and y hold steady from start until done
  assign lo_prod = x[vdm_pkg::LO_W-1:0] * y;
  assign hi_prod = x[vdm_pkg::DIST_W-1:vdm_pkg::LO_W] * y;
  assign t_sum   = {1'b0, hi_prod}
                 + {{(T_W-COORD_WIDTH){1'b0}}, plo_r[LO_PW-1:vdm_pkg::LO_W]};
  assign t_ovf   = |t_sum[T_W-1:vdm_pkg::HI_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= start;
      done_r <= ph_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      plo_r <= lo_prod;
    end
    if (ph_r) begin
      ovf_r  <= t_ovf;
      prod_r <= t_ovf ? vdm_pkg::DIST_MAX
                      : {t_sum[vdm_pkg::HI_W-1:0], plo_r[vdm_pkg::LO_W-1:0]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.prod = prod_r;

endmodule

`default_nettype wire

// ===== sv/vector_distance_metrics.sv =====
// ---------------------------------------------------------------------------
// vector_distance_metrics: streaming distance between two points
// Folds one coordinate pair per item into a saturating running total under
// the selected metric and returns the distance on the last pair.
// ---------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid / in_stall    in_coord_a, in_coord_b, in_last_coord
//  out      out  out_valid / out_stall  out_distance, out_saturated
//  cfg      in   cfg_we                 cfg_index, cfg_wdata
//
//  Per item: idle, then a start and a wait state on the one shared multiplier
//  for each multiply (one for squared Euclidean, p-1 for p-power, none for
//  supremum and trivial), then accumulate; a last pair adds an emit state.
//  Reset (synchronous, active low) clears the running total, the flag and
//  the registers to metric 0, p = 2. in_stall is high while an item is at
//  work; a last pair waits for the output register while out_stall holds it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vector_distance_metrics #(
  parameter int COORD_WIDTH = vdm_pkg::COORD_WIDTH_DEF,
  parameter int P_MAX       = vdm_pkg::P_MAX_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  signed [COORD_WIDTH-1:0]    in_coord_a,
  input  wire  signed [COORD_WIDTH-1:0]    in_coord_b,
  input  wire                              in_last_coord,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [vdm_pkg::DIST_W-1:0]       out_distance,
  output logic                             out_saturated,
  input  wire                              cfg_we,
  input  wire  [vdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [vdm_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int PW = $clog2(P_MAX + 1);
  localparam int DW = vdm_pkg::DIST_W;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_GO   = 3'd1;
  localparam logic [2:0] ST_MUL_WAIT = 3'd2;
  localparam logic [2:0] ST_ACC      = 3'd3;
  localparam logic [2:0] ST_EMIT     = 3'd4;

  logic [2:0]             state_r;
  logic [1:0]             metric_r;
  logic [3:0]             p_exp_r;
  logic [1:0]             item_metric_r;
  logic                   last_r;
  logic [COORD_WIDTH-1:0] ad_r;
  logic [DW-1:0]          pow_r;
  logic [PW-1:0]          cnt_r;
  logic [DW-1:0]          total_r;
  logic                   ovf_r;
  logic                   out_valid_r;
  logic [DW-1:0]          out_dist_r;
  logic                   out_sat_r;

  logic signed [COORD_WIDTH:0] diff;
  logic [COORD_WIDTH-1:0]      ad;
  logic [4:0]                  p5;
  logic [4:0]                  p_eff5;
  logic [PW-1:0]               mul_cnt;
  logic                        accept;
  logic                        out_free;
  logic [DW:0]                 sum;
  vdm_pkg::mul_rsp_t           mul_rsp;

  vdm_sat_mul #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(state_r == ST_MUL_GO),
    .x    (pow_r),
    .y    (ad_r),
    .rsp  (mul_rsp)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // |a - b| always fits in COORD_WIDTH unsigned bits
  assign diff = {in_coord_a[COORD_WIDTH-1], in_coord_a}
              - {in_coord_b[COORD_WIDTH-1], in_coord_b};
  assign ad   = diff[COORD_WIDTH] ? COORD_WIDTH'(-diff) : diff[COORD_WIDTH-1:0];

  always_comb begin
    p5 = {1'b0, p_exp_r};
    if (p5 == 5'd0) begin
      p_eff5 = 5'd1;
    end else if (p5 > 5'(P_MAX)) begin
      p_eff5 = 5'(P_MAX);
    end else begin
      p_eff5 = p5;
    end
    // power starts at |d|, so p-1 multiplies remain
    case (metric_r)
      vdm_pkg::METRIC_SQ_EUCLID: mul_cnt = PW'(1);
      vdm_pkg::METRIC_P_POWER:   mul_cnt = PW'(p_eff5 - 5'd1);
      default:                   mul_cnt = '0;
    endcase
  end

  assign sum = {1'b0, total_r} + {1'b0, pow_r};

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= vdm_pkg::METRIC_SQ_EUCLID;
      p_exp_r  <= vdm_pkg::P_EXP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vdm_pkg::REG_METRIC: metric_r <= cfg_wdata[1:0];
        vdm_pkg::REG_P_EXP:  p_exp_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken item unless a new one loads this cycle
      if (out_valid_r && !out_stall && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= (mul_cnt != '0) ? ST_MUL_GO : ST_ACC;
          end
        end
        ST_MUL_GO: begin
          state_r <= ST_MUL_WAIT;
        end
        ST_MUL_WAIT: begin
          if (mul_rsp.done) begin
            ovf_r   <= ovf_r | mul_rsp.ovf;
            state_r <= (cnt_r == PW'(1)) ? ST_ACC : ST_MUL_GO;
          end
        end
        ST_ACC: begin
          case (item_metric_r)
            vdm_pkg::METRIC_SUPREMUM: begin
              if ({{(DW-COORD_WIDTH){1'b0}}, ad_r} > total_r) begin
                total_r <= {{(DW-COORD_WIDTH){1'b0}}, ad_r};
              end
            end
            vdm_pkg::METRIC_TRIVIAL: begin
              if (ad_r != '0) begin
                total_r <= DW'(1);
              end
            end
            default: begin
              if (sum[DW]) begin
                total_r <= vdm_pkg::DIST_MAX;
                ovf_r   <= 1'b1;
              end else begin
                total_r <= sum[DW-1:0];
              end
            end
          endcase
          state_r <= last_r ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            total_r     <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_metric_r <= metric_r;
      last_r        <= in_last_coord;
      ad_r          <= ad;
      pow_r         <= {{(DW-COORD_WIDTH){1'b0}}, ad};
      cnt_r         <= mul_cnt;
    end else if (state_r == ST_MUL_WAIT && mul_rsp.done) begin
      pow_r <= mul_rsp.prod;
      cnt_r <= cnt_r - PW'(1);
    end
    if (state_r == ST_EMIT && out_free) begin
      out_dist_r <= total_r;
      out_sat_r  <= ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_distance  = out_dist_r;
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire

// ===== tb/tb_vector_distance_metrics.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_vector_distance_metrics: self-checking bench for the distance block
// Streams coordinate pairs under every metric and a range of exponent settings with
// random gaps on both channels. A local model mirrors the saturating
// running total, and every distance result is compared field by field.
// ---------------------------------------------------------------------------
module tb_vector_distance_metrics;

  localparam int CW            = vdm_pkg::COORD_WIDTH_DEF;
  localparam int P_LIMIT       = vdm_pkg::P_MAX_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 2000;

  typedef struct packed {
    logic [vdm_pkg::DIST_W-1:0] distance;
    logic                       saturated;
  } dist_result_t;

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          in_valid      = 1'b0;
  logic                          in_stall;
  logic signed [CW-1:0]          in_coord_a    = '0;
  logic signed [CW-1:0]          in_coord_b    = '0;
  logic                          in_last_coord = 1'b0;
  logic                          out_valid;
  logic                          out_stall     = 1'b0;
  logic [vdm_pkg::DIST_W-1:0]    out_distance;
  logic                          out_saturated;
  logic                          cfg_we        = 1'b0;
  logic [vdm_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic [vdm_pkg::CFG_W-1:0]     cfg_wdata     = '0;

  // local copy of the block's registers and accumulator
  logic [1:0]                 cur_metric;
  logic [3:0]                 cur_p_exp;
  logic [vdm_pkg::DIST_W-1:0] run_total;
  bit                         run_ovf;

  dist_result_t dist_expected_q[$];
  int           fail_count = 0;
  bit           quiet_mode = 1'b0;
  int           stall_left = 0;

  vector_distance_metrics DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_coord_a    (in_coord_a),
    .in_coord_b    (in_coord_b),
    .in_last_coord (in_last_coord),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_distance  (out_distance),
    .out_saturated (out_saturated),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [vdm_pkg::DIST_W-1:0] clamp_mul(
      input logic [vdm_pkg::DIST_W-1:0] x,
      input logic [vdm_pkg::DIST_W-1:0] y,
      inout bit ovf);
    logic [2*vdm_pkg::DIST_W-1:0] prod;
    prod = {{vdm_pkg::DIST_W{1'b0}}, x} * {{vdm_pkg::DIST_W{1'b0}}, y};
    if (prod > {{vdm_pkg::DIST_W{1'b0}}, vdm_pkg::DIST_MAX}) begin
      ovf = 1'b1;
      return vdm_pkg::DIST_MAX;
    end
    return prod[vdm_pkg::DIST_W-1:0];
  endfunction

  function automatic logic [vdm_pkg::DIST_W-1:0] clamp_add(
      input logic [vdm_pkg::DIST_W-1:0] x,
      input logic [vdm_pkg::DIST_W-1:0] y,
      inout bit ovf);
    logic [vdm_pkg::DIST_W:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum > {1'b0, vdm_pkg::DIST_MAX}) begin
      ovf = 1'b1;
      return vdm_pkg::DIST_MAX;
    end
    return sum[vdm_pkg::DIST_W-1:0];
  endfunction

  // fold one accepted pair into the running total; queue a result on the last pair
  task automatic fold_coord_pair(input logic signed [CW-1:0] a,
                                 input logic signed [CW-1:0] b,
                                 input logic last);
    longint                     diff;
    logic [vdm_pkg::DIST_W-1:0] mag;
    logic [vdm_pkg::DIST_W-1:0] term;
    int                         pw;
    diff = longint'(a) - longint'(b);
    mag  = (diff < 0) ? vdm_pkg::DIST_W'(-diff) : vdm_pkg::DIST_W'(diff);
    pw   = int'(cur_p_exp);
    if (pw == 0) pw = 1;
    if (pw > P_LIMIT) pw = P_LIMIT;
    case (cur_metric)
      vdm_pkg::METRIC_SQ_EUCLID: begin
        term      = clamp_mul(mag, mag, run_ovf);
        run_total = clamp_add(run_total, term, run_ovf);
      end
      vdm_pkg::METRIC_SUPREMUM: begin
        if (mag > run_total) run_total = mag;
      end
      vdm_pkg::METRIC_TRIVIAL: begin
        if (mag != '0) run_total = vdm_pkg::DIST_W'(1);
      end
      default: begin
        term = vdm_pkg::DIST_W'(1);
        for (int i = 0; i < pw; i++) term = clamp_mul(term, mag, run_ovf);
        run_total = clamp_add(run_total, term, run_ovf);
      end
    endcase
    if (last) begin
      dist_expected_q.push_back('{distance: run_total, saturated: run_ovf});
      run_total = '0;
      run_ovf   = 1'b0;
    end
  endtask

  task automatic send_pair(input logic signed [CW-1:0] a,
                           input logic signed [CW-1:0] b,
                           input logic last);
    int gap;
    gap = quiet_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_coord_a    <= a;
    in_coord_b    <= b;
    in_last_coord <= last;
    do @(posedge clk); while (in_stall);
    fold_coord_pair(a, b, last);
  endtask

  // hold the input idle until every result is back and the block is quiet
  task automatic drain_results();
    in_valid <= 1'b0;
    while (dist_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [vdm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vdm_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == vdm_pkg::REG_METRIC) cur_metric = data[1:0];
    else cur_p_exp = data;
  endtask

  task automatic reconfigure(input logic [1:0] metric, input logic [3:0] p_exp);
    drain_results();
    cfg_write(vdm_pkg::REG_METRIC, {2'b00, metric});
    cfg_write(vdm_pkg::REG_P_EXP, p_exp);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 45) return CW'($urandom());
    if (r < 80) return CW'(int'($urandom_range(16)) - 8);
    case ($urandom_range(3))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [3:0] pick_p_exp();
    case ($urandom_range(7))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'(P_LIMIT);
      3: return 4'd15;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    send_pair(16'sd5, 16'sd5, 1'b1);
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(-16'sd3, 16'sd4, 1'b0);
    send_pair(16'sd100, -16'sd100, 1'b1);
  endtask

  task automatic test_metric_modes();
    reconfigure(vdm_pkg::METRIC_SUPREMUM, vdm_pkg::P_EXP_RESET);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(-16'sd32768, 16'sd32767, 1'b0);
    send_pair(16'sd10, 16'sd3, 1'b1);
    reconfigure(vdm_pkg::METRIC_TRIVIAL, vdm_pkg::P_EXP_RESET);
    send_pair(16'sd4, 16'sd4, 1'b0);
    send_pair(16'sd4, 16'sd4, 1'b1);
    send_pair(16'sd0, 16'sd1, 1'b1);
  endtask

  task automatic test_exponent_limits();
    reconfigure(vdm_pkg::METRIC_P_POWER, 4'(P_LIMIT));
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    send_pair(-16'sd2, 16'sd0, 1'b1);
    reconfigure(vdm_pkg::METRIC_P_POWER, 4'd4);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    // zero exponent acts as one, values above the maximum clamp to it
    reconfigure(vdm_pkg::METRIC_P_POWER, 4'd0);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    reconfigure(vdm_pkg::METRIC_P_POWER, 4'd15);
    send_pair(16'sd3, 16'sd1, 1'b1);
  endtask

  task automatic test_metric_switch();
    reconfigure(vdm_pkg::METRIC_P_POWER, 4'd3);
    send_pair(16'sd10, 16'sd0, 1'b0);
    reconfigure(vdm_pkg::METRIC_SUPREMUM, 4'd3);
    send_pair(16'sd3, 16'sd0, 1'b0);
    reconfigure(vdm_pkg::METRIC_SQ_EUCLID, 4'd3);
    send_pair(16'sd2, 16'sd0, 1'b1);
  endtask

  task automatic test_random_vectors(input int n_items);
    int                   sent;
    int                   len;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(19) == 0) reconfigure(2'($urandom_range(3)), pick_p_exp());
      quiet_mode <= ($urandom_range(7) == 0);
      len = ($urandom_range(9) == 0) ? $urandom_range(32, 7) : $urandom_range(6, 1);
      for (int k = 0; k < len; k++) begin
        a = pick_coord();
        b = ($urandom_range(6) == 0) ? a : pick_coord();
        // switch the metric between pairs of one vector now and then
        if (k > 0 && $urandom_range(39) == 0)
          reconfigure(2'($urandom_range(3)), pick_p_exp());
        send_pair(a, b, k == len - 1);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    dist_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (dist_expected_q.size() == 0) begin
        $error("distance: no result expected, got %0d", out_distance);
        fail_count++;
      end else begin
        want = dist_expected_q.pop_front();
        if (out_distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, out_distance);
          fail_count++;
        end
        if (out_saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_saturated);
          fail_count++;
        end
      end
    end
    if (quiet_mode) stall_left = 0;
    else if (stall_left == 0 && $urandom_range(3) == 0) stall_left = pick_gap();
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  initial begin
    cur_metric = vdm_pkg::METRIC_SQ_EUCLID;
    cur_p_exp  = vdm_pkg::P_EXP_RESET;
    run_total  = '0;
    run_ovf    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_metric_modes();
    test_exponent_limits();
    test_metric_switch();
    test_random_vectors(RANDOM_ITEMS);
    quiet_mode <= 1'b0;
    drain_results();
    if (fail_count == 0) $display("[vector_distance_metrics] OK");
    else $display("[vector_distance_metrics] ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[vector_distance_metrics] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/vdm_pkg.sv
sv/vdm_sat_mul.sv
sv/vector_distance_metrics.sv
tb/tb_vector_distance_metrics.sv
